// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion forms, clocked on a rising edge with an
// active-low reset that disables the check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition on one edge implies a consequence on the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// condition holds on every edge out of reset
`define ASSERT_NOW(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant check failed");

`endif

// ===== hw/rtl/bds_pkg.sv =====
// ----------------------------------------------------------------------------
// bds_pkg
// shared constants of the binary descriptor sampler: bus widths, register
// map, reset values and parameter defaults
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_PAIRS  = 512;

    localparam int TDATA_IN_W  = 128;
    localparam int TDATA_OUT_W = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int DIM_W       = 9;
    localparam int SCALE_W     = 20;
    localparam int SUM_W       = 19;
    localparam int IDX_W       = 9;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DESC_SCALE   = 2'd2;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [SCALE_W-1:0] RST_DESC_SCALE   = 20'd16384;

    localparam logic [SUM_W:0] SUM_MAX = 20'd524287;

endpackage

// ===== hw/rtl/binary_descriptor_sampler_core.sv =====
// ----------------------------------------------------------------------------
// binary_descriptor_sampler_core
// pixel write beats: one per cycle while the sequencer is idle, stored on the
// accepting edge; sample beats: result valid after offset scaling, then the
// cell, address, base, read and lerp steps for each point, plus any wait of
// the previous result on m_tready; next sample taken the cycle after the result
// is loaded; one shared multiplier serves 12 products, one read port 8 pixel reads
// reset (aresetn low, synchronous): sequencer idle, counters and sum zero,
// registers to defaults; image store keeps its contents and is not cleared
// ----------------------------------------------------------------------------
module binary_descriptor_sampler_core #(
    parameter int MAX_WIDTH  = bds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PAIRS  = bds_pkg::DEF_MAX_PAIRS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_addr, pixel_value, key_x, key_y, first_dx, first_dy,
    // second_dx, second_dy, zero pad
    input  logic [bds_pkg::TDATA_IN_W-1:0]    s_tdata,
    // req_type
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // compare_bit, bit_index, diff_sum, zero pad
    output logic [bds_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bds_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bds_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bds_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(STORE_SIZE);
    localparam int PW         = $clog2(MAX_PAIRS);
    localparam int DW         = bds_pkg::DIM_W;
    localparam logic [2:0] LAST_STEP = 3'd4;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCALE  = 8'b0000_0010,
        ST_CELL   = 8'b0000_0100,
        ST_ADDR   = 8'b0000_1000,
        ST_BASE   = 8'b0001_0000,
        ST_READ   = 8'b0010_0000,
        ST_LERP   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    function automatic logic [DW-1:0] clamp_cell(input logic signed [15:0] v,
                                                 input logic [DW-1:0] hi);
        logic [DW-1:0] r;
        if (v < 16'sd0) begin
            r = '0;
        end else if (v > $signed({7'b0, hi})) begin
            r = hi;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // input beat fields
    logic [15:0]        in_addr;
    logic [7:0]         in_value;
    logic [17:0]        in_kx, in_ky;
    logic signed [15:0] in_off [4];

    assign in_addr   = s_tdata[15:0];
    assign in_value  = s_tdata[23:16];
    assign in_kx     = s_tdata[41:24];
    assign in_ky     = s_tdata[59:42];
    assign in_off[0] = s_tdata[75:60];
    assign in_off[1] = s_tdata[91:76];
    assign in_off[2] = s_tdata[107:92];
    assign in_off[3] = s_tdata[123:108];

    // registers
    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               pt_reg, pt_next;
    logic [DW-1:0]      width_reg, width_next;
    logic [DW-1:0]      height_reg, height_next;
    logic [bds_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [17:0]        key_x_reg, key_x_next;
    logic [17:0]        key_y_reg, key_y_next;
    logic signed [15:0] offs_reg [4];
    logic signed [15:0] offs_next [4];
    logic               last_reg, last_next;
    logic signed [25:0] pos_reg [4];
    logic signed [25:0] pos_next [4];
    logic [DW-1:0]      xr_reg, xr_next;
    logic [DW-1:0]      yr_reg, yr_next;
    logic [9:0]         fx_reg, fx_next;
    logic [9:0]         fy_reg, fy_next;
    logic signed [37:0] prod_reg;
    logic [AW-1:0]      base_reg, base_next;
    logic [7:0]         rd_data_reg;
    logic [7:0]         pix_reg [4];
    logic [7:0]         pix_next [4];
    logic [8:0]         c1_reg, c1_next;
    logic [8:0]         c2_reg, c2_next;
    logic [9:0]         v_reg [2];
    logic [9:0]         v_next [2];
    logic [PW-1:0]      pc_reg, pc_next;
    logic [bds_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_cmp_reg, m_cmp_next;
    logic [bds_pkg::IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [bds_pkg::SUM_W-1:0] m_sum_reg, m_sum_next;
    logic               m_last_reg, m_last_next;

    logic [7:0] image_mem [STORE_SIZE];

    // datapath signals
    logic [DW-1:0]      w_eff, h_eff;
    logic signed [25:0] px, py;
    logic signed [15:0] xi, yi;
    logic signed [20:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [37:0] mul_p;
    logic signed [37:0] scaled;
    logic [1:0]         kidx;
    logic [11:0]        lerp_sh, c1_sum, c2_sum, v_sum;
    logic signed [8:0]  da, db;
    logic signed [9:0]  dc;
    logic [AW-1:0]      rd_ofs, rd_addr;
    logic               wr_en;
    logic [9:0]         abs_diff;
    logic [bds_pkg::SUM_W:0] sum_wide;
    logic               cfg_wr;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, m_sum_reg, m_idx_reg, m_cmp_reg};
    assign m_tlast  = m_last_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            bds_pkg::REG_IMAGE_WIDTH:  prdata = {23'b0, width_reg};
            bds_pkg::REG_IMAGE_HEIGHT: prdata = {23'b0, height_reg};
            bds_pkg::REG_DESC_SCALE:   prdata = {12'b0, scale_reg};
            default:                   prdata = '0;
        endcase
    end

    // dimensions clamped to at least 2 and saturated to the store
    always_comb begin
        if (width_reg < 9'd2) begin
            w_eff = 9'd2;
        end else if ({23'b0, width_reg} > 32'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < 9'd2) begin
            h_eff = 9'd2;
        end else if ({23'b0, height_reg} > 32'(MAX_HEIGHT)) begin
            h_eff = DW'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign px = pt_reg ? pos_reg[2] : pos_reg[0];
    assign py = pt_reg ? pos_reg[3] : pos_reg[1];
    assign xi = 16'(px >>> 10);
    assign yi = 16'(py >>> 10);

    assign da = $signed({1'b0, pix_reg[1]}) - $signed({1'b0, pix_reg[0]});
    assign db = $signed({1'b0, pix_reg[3]}) - $signed({1'b0, pix_reg[2]});
    assign dc = $signed({1'b0, c2_reg}) - $signed({1'b0, c1_reg});

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SCALE: begin
                mul_a = $signed({1'b0, scale_reg});
                mul_b = {offs_reg[cnt_reg[1:0]][15], offs_reg[cnt_reg[1:0]]};
            end
            ST_ADDR: begin
                mul_a = $signed({12'b0, yr_reg});
                mul_b = $signed({8'b0, w_eff});
            end
            ST_LERP: begin
                case (cnt_reg)
                    3'd0: begin
                        mul_a = 21'(da);
                        mul_b = $signed({7'b0, fx_reg});
                    end
                    3'd1: begin
                        mul_a = 21'(db);
                        mul_b = $signed({7'b0, fx_reg});
                    end
                    3'd3: begin
                        mul_a = 21'(dc);
                        mul_b = $signed({7'b0, fy_reg});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 38'(mul_a) * 38'(mul_b);

    // offset scaling truncates toward zero
    assign scaled = (prod_reg < 38'sd0) ? ((prod_reg + 38'sd4095) >>> 12)
                                        : (prod_reg >>> 12);
    assign kidx   = 2'(cnt_reg - 3'd1);

    assign lerp_sh = 12'(prod_reg >>> 9);
    assign c1_sum  = lerp_sh + {3'b0, pix_reg[0], 1'b0};
    assign c2_sum  = lerp_sh + {3'b0, pix_reg[2], 1'b0};
    assign v_sum   = lerp_sh + {2'b0, c1_reg, 1'b0};

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    rd_ofs = '0;
            2'd1:    rd_ofs = AW'(1);
            2'd2:    rd_ofs = AW'(w_eff);
            default: rd_ofs = AW'(w_eff) + AW'(1);
        endcase
    end

    assign rd_addr = base_reg + rd_ofs;
    assign wr_en   = s_tvalid && s_tready && !s_tuser
                     && ({16'b0, in_addr} < 32'(STORE_SIZE));

    assign abs_diff = (v_reg[1] > v_reg[0]) ? (v_reg[1] - v_reg[0])
                                            : (v_reg[0] - v_reg[1]);
    assign sum_wide = {1'b0, sum_reg} + {10'b0, abs_diff};

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pt_next      = pt_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        scale_next   = scale_reg;
        key_x_next   = key_x_reg;
        key_y_next   = key_y_reg;
        offs_next    = offs_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        xr_next      = xr_reg;
        yr_next      = yr_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        base_next    = base_reg;
        pix_next     = pix_reg;
        c1_next      = c1_reg;
        c2_next      = c2_reg;
        v_next       = v_reg;
        pc_next      = pc_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        m_cmp_next   = m_cmp_reg;
        m_idx_next   = m_idx_reg;
        m_sum_next   = m_sum_reg;
        m_last_next  = m_last_reg;

        if (cfg_wr) begin
            case (paddr[3:2])
                bds_pkg::REG_IMAGE_WIDTH:  width_next  = pwdata[DW-1:0];
                bds_pkg::REG_IMAGE_HEIGHT: height_next = pwdata[DW-1:0];
                bds_pkg::REG_DESC_SCALE:   scale_next  = pwdata[bds_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser) begin
                    key_x_next = in_kx;
                    key_y_next = in_ky;
                    offs_next  = in_off;
                    last_next  = s_tlast;
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (cnt_reg != 3'd0) begin
                    pos_next[kidx] = $signed({8'b0, (kidx[0] ? key_y_reg : key_x_reg)})
                                     + 26'(scaled);
                end
                if (cnt_reg == LAST_STEP) begin
                    cnt_next   = '0;
                    pt_next    = 1'b0;
                    state_next = ST_CELL;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_CELL: begin
                xr_next    = clamp_cell(xi, w_eff - 9'd2);
                yr_next    = clamp_cell(yi, h_eff - 9'd2);
                fx_next    = px[9:0];
                fy_next    = py[9:0];
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                state_next = ST_BASE;
            end
            ST_BASE: begin
                base_next  = AW'(prod_reg[17:0] + {9'b0, xr_reg});
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_READ: begin
                if (cnt_reg != 3'd0) begin
                    pix_next[kidx] = rd_data_reg;
                end
                if (cnt_reg == LAST_STEP) begin
                    cnt_next   = '0;
                    state_next = ST_LERP;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_LERP: begin
                case (cnt_reg)
                    3'd1:    c1_next = c1_sum[8:0];
                    3'd2:    c2_next = c2_sum[8:0];
                    3'd4:    v_next[pt_reg] = v_sum[9:0];
                    default: ;
                endcase
                if (cnt_reg == LAST_STEP) begin
                    cnt_next = '0;
                    if (pt_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        pt_next    = 1'b1;
                        state_next = ST_CELL;
                    end
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_cmp_next   = (v_reg[1] < v_reg[0]);
                    m_idx_next   = bds_pkg::IDX_W'(pc_reg);
                    m_sum_next   = (sum_wide > bds_pkg::SUM_MAX) ? '1
                                                                : sum_wide[bds_pkg::SUM_W-1:0];
                    m_last_next  = last_reg;
                    if (last_reg) begin
                        pc_next  = '0;
                        sum_next = '0;
                    end else begin
                        pc_next  = (pc_reg == PW'(MAX_PAIRS - 1)) ? '0 : pc_reg + PW'(1);
                        sum_next = (sum_wide > bds_pkg::SUM_MAX) ? '1
                                                                : sum_wide[bds_pkg::SUM_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pt_reg      <= 1'b0;
            width_reg   <= bds_pkg::RST_IMAGE_WIDTH;
            height_reg  <= bds_pkg::RST_IMAGE_HEIGHT;
            scale_reg   <= bds_pkg::RST_DESC_SCALE;
            pc_reg      <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pt_reg      <= pt_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            scale_reg   <= scale_next;
            pc_reg      <= pc_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_x_reg  <= key_x_next;
        key_y_reg  <= key_y_next;
        offs_reg   <= offs_next;
        last_reg   <= last_next;
        pos_reg    <= pos_next;
        xr_reg     <= xr_next;
        yr_reg     <= yr_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        prod_reg   <= mul_p;
        base_reg   <= base_next;
        pix_reg    <= pix_next;
        c1_reg     <= c1_next;
        c2_reg     <= c2_next;
        v_reg      <= v_next;
        m_cmp_reg  <= m_cmp_next;
        m_idx_reg  <= m_idx_next;
        m_sum_reg  <= m_sum_next;
        m_last_reg <= m_last_next;
    end

    // image store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            image_mem[AW'(in_addr)] <= in_value;
        end
        rd_data_reg <= image_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/bds_checker.sv =====
// ----------------------------------------------------------------------------
// bds_checker
// port-level checks of the descriptor sampler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bds_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bds_pkg::TDATA_OUT_W-1:0]   m_tdata,
    input logic                              m_tlast,
    input logic                              pready
);

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable({m_tlast, m_tdata}))

    // a sample beat keeps the input closed while it is worked on
    `ASSERT_NEXT(a_sample_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready)

    // pixel writes never stall the input
    `ASSERT_NEXT(a_write_free, aclk, aresetn, s_tvalid && s_tready && !s_tuser, s_tready)

    `ASSERT_NOW(a_pready, aclk, aresetn, pready)

endmodule

bind binary_descriptor_sampler_core bds_checker u_bds_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// feeds pixel write beats and test pair beats into the descriptor sampler,
// predicts compare bit, bit index, running difference total and end flag for
// every test pair, and checks each result beat in order against the oldest
// prediction while both stream sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         STORE_DEPTH   = bds_pkg::DEF_MAX_WIDTH * bds_pkg::DEF_MAX_HEIGHT;

    typedef struct packed {
        bit                      cmp;
        bit [bds_pkg::IDX_W-1:0] idx;
        bit [bds_pkg::SUM_W-1:0] total;
        bit                      done;
    } pair_result_t;

    class descriptor_tracker;
        bit [bds_pkg::DIM_W-1:0]   width_reg;
        bit [bds_pkg::DIM_W-1:0]   height_reg;
        bit [bds_pkg::SCALE_W-1:0] scale_reg;
        bit [7:0]                  image [STORE_DEPTH];
        bit [bds_pkg::IDX_W-1:0]   pair_count;
        bit [bds_pkg::SUM_W-1:0]   diff_total;
        pair_result_t              bits_due [$];
        int                        errors;

        function new();
            width_reg  = bds_pkg::RST_IMAGE_WIDTH;
            height_reg = bds_pkg::RST_IMAGE_HEIGHT;
            scale_reg  = bds_pkg::RST_DESC_SCALE;
            pair_count = '0;
            diff_total = '0;
            errors     = 0;
        endfunction

        function int clamp_dim(input int v, input int top);
            return (v < 2) ? 2 : ((v > top) ? top : v);
        endfunction

        function void set_reg(input logic [1:0] index,
                              input logic [bds_pkg::CFG_DATA_W-1:0] value);
            case (index)
                bds_pkg::REG_IMAGE_WIDTH: begin
                    width_reg = value[bds_pkg::DIM_W-1:0];
                end
                bds_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg = value[bds_pkg::DIM_W-1:0];
                end
                bds_pkg::REG_DESC_SCALE: begin
                    scale_reg = value[bds_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // offset in 1/1024 pixel, truncated toward zero
        function longint offset_units(input logic signed [15:0] q12);
            return (longint'(scale_reg) * longint'(q12)) / 4096;
        endfunction

        function int lerp_point(input longint px, input longint py, input int w, input int h);
            longint cx, cy;
            int fx, fy, base, a0, a1, b0, b1, c1, c2;
            cx = px >>> 10;
            cy = py >>> 10;
            fx = int'(px & 64'd1023);
            fy = int'(py & 64'd1023);
            if (cx < 0) cx = 0;
            if (cy < 0) cy = 0;
            if (cx > w - 2) cx = w - 2;
            if (cy > h - 2) cy = h - 2;
            base = int'(cx + cy * w);
            a0 = image[base];
            a1 = image[base + 1];
            b0 = image[base + w];
            b1 = image[base + w + 1];
            c1 = (((a1 - a0) * fx) >>> 9) + 2 * a0;
            c2 = (((b1 - b0) * fx) >>> 9) + 2 * b0;
            return (((c2 - c1) * fy) >>> 9) + 2 * c1;
        endfunction

        function void take_request(input logic user,
                                   input logic [bds_pkg::TDATA_IN_W-1:0] data,
                                   input logic last);
            int w, h, v1, v2, diff;
            longint kx, ky, grown;
            pair_result_t res;
            if (user == 1'b0) begin
                image[data[15:0]] = data[23:16];
                return;
            end
            w  = clamp_dim(width_reg, bds_pkg::DEF_MAX_WIDTH);
            h  = clamp_dim(height_reg, bds_pkg::DEF_MAX_HEIGHT);
            kx = longint'(data[41:24]);
            ky = longint'(data[59:42]);
            v1 = lerp_point(kx + offset_units(data[75:60]), ky + offset_units(data[91:76]), w, h);
            v2 = lerp_point(kx + offset_units(data[107:92]), ky + offset_units(data[123:108]),
                            w, h);
            diff  = (v2 > v1) ? v2 - v1 : v1 - v2;
            grown = longint'(diff_total) + diff;
            if (grown > bds_pkg::SUM_MAX) grown = bds_pkg::SUM_MAX;
            res.cmp   = (v2 < v1);
            res.idx   = pair_count;
            res.total = grown[bds_pkg::SUM_W-1:0];
            res.done  = last;
            bits_due.push_back(res);
            diff_total = res.total;
            if (last) begin
                pair_count = '0;
                diff_total = '0;
            end else begin
                pair_count = pair_count + 1'b1;
            end
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 100) $display("mismatch: %s", what);
        endtask

        task check_bit(input logic [bds_pkg::TDATA_OUT_W-1:0] data, input logic last);
            pair_result_t want;
            if (bits_due.size() == 0) begin
                report("result beat with no prediction waiting");
                return;
            end
            want = bits_due.pop_front();
            if (data[0] !== want.cmp)
                report($sformatf("bit %0d compare_bit %b, want %b", want.idx, data[0], want.cmp));
            if (data[9:1] !== want.idx)
                report($sformatf("bit_index %0d, want %0d", data[9:1], want.idx));
            if (data[28:10] !== want.total)
                report($sformatf("bit %0d diff_sum %0d, want %0d", want.idx, data[28:10],
                                 want.total));
            if (last !== want.done)
                report($sformatf("bit %0d done flag %b, want %b", want.idx, last, want.done));
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bds_pkg::TDATA_IN_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [bds_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bds_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [bds_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [bds_pkg::CFG_DATA_W-1:0]  prdata;
    logic                            pready;

    bit                written [STORE_DEPTH];
    int                src_calm;
    descriptor_tracker tracker = new();

    binary_descriptor_sampler_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    initial begin
        int stall, calm;
        stall = 0;
        calm  = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap(calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tracker.take_request(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) tracker.check_bit(m_tdata, m_tlast);
        end
    end

    task automatic push_beat(input logic user, input logic [bds_pkg::TDATA_IN_W-1:0] data,
                             input logic last);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // sample fields and tlast carry noise on a write beat
    task automatic write_pixel(input logic [15:0] addr, input logic [7:0] value);
        logic [bds_pkg::TDATA_IN_W-1:0] word;
        word = {$urandom, $urandom, $urandom, $urandom};
        word[bds_pkg::TDATA_IN_W-1:124] = '0;
        word[23:0] = {value, addr};
        written[addr] = 1'b1;
        push_beat(1'b0, word, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_pair(input logic [17:0] kx, ky, input logic [15:0] fdx, fdy, sdx, sdy,
                             input logic last);
        logic [bds_pkg::TDATA_IN_W-1:0] word;
        word = '0;
        word[23:0] = 24'($urandom);
        word[123:24] = {sdy, sdx, fdy, fdx, ky, kx};
        push_beat(1'b1, word, last);
    endtask

    task automatic reg_write(input logic [1:0] index,
                             input logic [bds_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(index, value);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.bits_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // every pixel a sample can touch must hold a written value
    task automatic fill_image();
        int w, h;
        w = tracker.clamp_dim(tracker.width_reg, bds_pkg::DEF_MAX_WIDTH);
        h = tracker.clamp_dim(tracker.height_reg, bds_pkg::DEF_MAX_HEIGHT);
        for (int a = 0; a < w * h; a++) begin
            if (!written[a]) write_pixel(16'(a), 8'($urandom));
        end
    endtask

    function automatic logic [17:0] pick_key(input int n);
        if ($urandom_range(0, 9) < 3) return 18'($urandom);
        return 18'($urandom_range(0, n * 1024 - 1));
    endfunction

    function automatic logic [15:0] pick_offset();
        if ($urandom_range(0, 1) == 1) return 16'($urandom);
        return 16'($urandom_range(0, 4095) - 2048);
    endfunction

    task automatic random_phase(input int wv, input int hv, input int sv, input int items);
        int w, h, sent, len;
        logic last;
        drain();
        reg_write(bds_pkg::REG_IMAGE_WIDTH, (32'($urandom) << bds_pkg::DIM_W) | 32'(wv));
        reg_write(bds_pkg::REG_IMAGE_HEIGHT, (32'($urandom) << bds_pkg::DIM_W) | 32'(hv));
        reg_write(bds_pkg::REG_DESC_SCALE, 32'(sv));
        reg_write(REG_UNUSED, $urandom);
        fill_image();
        w = tracker.clamp_dim(tracker.width_reg, bds_pkg::DEF_MAX_WIDTH);
        h = tracker.clamp_dim(tracker.height_reg, bds_pkg::DEF_MAX_HEIGHT);
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 99) < 12) begin
                write_pixel(16'($urandom), 8'($urandom));
                sent++;
            end else begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    // now and then a descriptor runs on without its end flag
                    last = (i == len - 1) && ($urandom_range(0, 5) != 0);
                    send_pair(pick_key(w), pick_key(h), pick_offset(), pick_offset(),
                              pick_offset(), pick_offset(), last);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        src_calm = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small image, scale left at its reset value
        reg_write(bds_pkg::REG_IMAGE_WIDTH, 32'd8);
        reg_write(bds_pkg::REG_IMAGE_HEIGHT, 32'd8);
        fill_image();
        send_pair(18'd0, 18'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pair(18'h3ffff, 18'h3ffff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b0);
        send_pair(18'd0, 18'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0);
        send_pair(18'(3 * 1024 + 512), 18'(2 * 1024 + 300), 16'h0000, 16'h0000,
                  16'h0100, 16'h0100, 1'b0);
        write_pixel(16'd27, 8'd255);
        send_pair(18'(5 * 1024 + 1023), 18'(6 * 1024 + 1), 16'hffff, 16'h0001,
                  16'h0001, 16'hffff, 1'b0);
        send_pair(18'(7 * 1024), 18'(7 * 1024), 16'h1000, 16'h0000, 16'h0000, 16'h1000, 1'b1);
        send_pair(18'(1024 + 100), 18'(1024 + 900), 16'hff00, 16'h0100, 16'h0080, 16'hff80,
                  1'b0);
        send_pair(18'(2 * 1024 + 7), 18'(4 * 1024 + 1000), 16'h0040, 16'hffc0, 16'hff40,
                  16'h00c0, 1'b1);

        // odd scale: negative offsets truncate toward zero
        drain();
        reg_write(bds_pkg::REG_DESC_SCALE, 32'd1023);
        send_pair(18'(4 * 1024), 18'(4 * 1024), 16'hfffd, 16'h0003, 16'hfff1, 16'h000f, 1'b0);
        send_pair(18'(4 * 1024 + 5), 18'(3 * 1024 + 9), 16'hffff, 16'h0001, 16'h8000,
                  16'h7fff, 1'b1);

        random_phase(256, 2, 0, 6);
        random_phase(2, 256, 1048575, 6);
        random_phase(511, 0, 16384, 6);
        random_phase(1, 300, $urandom, 6);
        random_phase(2, 2, $urandom_range(0, 65535), 6);
        for (int p = 0; p < 4; p++)
            random_phase($urandom_range(2, 16), $urandom_range(2, 16),
                         $urandom_range(0, 1048575), 6);

        // one long high-contrast descriptor: total saturates, bit index wraps
        drain();
        reg_write(bds_pkg::REG_IMAGE_WIDTH, 32'd4);
        reg_write(bds_pkg::REG_IMAGE_HEIGHT, 32'd2);
        reg_write(bds_pkg::REG_DESC_SCALE, 32'(bds_pkg::RST_DESC_SCALE));
        for (int a = 0; a < 8; a++)
            write_pixel(16'(a), (((a ^ (a >> 2)) & 1) == 1) ? 8'd255 : 8'd0);
        for (int i = 0; i < 520; i++)
            send_pair(18'($urandom_range(0, 1) * 1024), 18'($urandom_range(0, 1) * 1024),
                      16'h0000, 16'h0000, 16'h0100, 16'h0000, i == 519);

        drain();
        if (tracker.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
